/* src/pmi_pkg.sv */
// shared types, constants and fixed-point helpers for the particle motion integrator
`timescale 1ns / 1ps

package pmi_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned MAG_W   = 31;
    localparam int unsigned DT_W    = 17;
    localparam int unsigned SQRT_N  = 32;
    localparam int unsigned DIV_N   = 31;

    // three signed q16.16 components, carried as raw bits
    typedef logic [2:0][WORD_W-1:0] t_vec3;

    typedef enum logic [1:0] {
        ST_KEEP = 2'd0,
        ST_STOP = 2'd1,
        ST_CAP  = 2'd2
    } t_status;

    // payload that rides beside the arithmetic in every stage
    typedef struct packed {
        t_vec3           vel;
        t_vec3           pos;
        logic [DT_W-1:0] dt;
        logic [MAG_W-1:0] cap;
        t_status         status;
    } t_side;

    // round half up, drop 16 fraction bits
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
        rnd16 = (p + 64'sd32768) >>> 16;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic [WORD_W-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            sat32 = 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[WORD_W-1:0];
        end
    endfunction

endpackage

/* src/particle_motion_integrator.sv */
// top level of the particle motion integrator
`timescale 1ns / 1ps
//
// Advances one body per word: velocity gains acc*dt, loses linear drag, is
// stopped at or below 0.5 or when the cap is zero, rescaled when above the
// cap; position then advances by v*dt with y floored at zero. All signed
// q16.16 with saturation.
// Input channel: i_valid / o_ready with one port per field. Output channel:
// o_valid / i_ready. A word moves when valid and ready are both high.
// Pipeline: 7 front stages, 32 square-root stages (one root bit
// each), 33 division stages (product, 31 quotient bits, sign fix) and 2
// position stages. Throughput is one word per cycle unless the output stalls.
// The whole pipeline advances together; when the receiver holds i_ready low
// with a word waiting in the output register, every stage holds and o_ready
// drops, so nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
//
module particle_motion_integrator
    import pmi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_vel_x,
    input  logic signed [31:0]  i_vel_y,
    input  logic signed [31:0]  i_vel_z,
    input  logic signed [31:0]  i_acc_x,
    input  logic signed [31:0]  i_acc_y,
    input  logic signed [31:0]  i_acc_z,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic [30:0]         i_drag_coef,
    input  logic [30:0]         i_speed_cap,
    input  logic [16:0]         i_time_step,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_new_vel_x,
    output logic signed [31:0]  o_new_vel_y,
    output logic signed [31:0]  o_new_vel_z,
    output logic signed [31:0]  o_new_pos_x,
    output logic [30:0]         o_new_pos_y,
    output logic signed [31:0]  o_new_pos_z,
    output logic [1:0]          o_speed_status
);

    logic              w_ce;
    logic              w_f_vld, w_s_vld, w_d_vld;
    t_side             w_f_side, w_s_side, w_d_side;
    logic [63:0]       w_s2;
    logic [SQRT_N-1:0] w_root;
    t_vec3             w_vel, w_pos;
    t_status           w_status;

    // global advance: output empty or being taken
    assign w_ce    = !o_valid || i_ready;
    assign o_ready = w_ce;

    pmi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (i_valid),
        .i_vel   ({i_vel_z, i_vel_y, i_vel_x}),
        .i_acc   ({i_acc_z, i_acc_y, i_acc_x}),
        .i_pos   ({i_pos_z, i_pos_y, i_pos_x}),
        .i_drag  (i_drag_coef),
        .i_cap   (i_speed_cap),
        .i_dt    (i_time_step),
        .o_valid (w_f_vld),
        .o_side  (w_f_side),
        .o_s2    (w_s2)
    );

    pmi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_f_vld),
        .i_side  (w_f_side),
        .i_s2    (w_s2),
        .o_valid (w_s_vld),
        .o_side  (w_s_side),
        .o_root  (w_root)
    );

    pmi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_s_vld),
        .i_side  (w_s_side),
        .i_root  (w_root),
        .o_valid (w_d_vld),
        .o_side  (w_d_side)
    );

    pmi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (w_ce),
        .i_valid  (w_d_vld),
        .i_side   (w_d_side),
        .o_valid  (o_valid),
        .o_vel    (w_vel),
        .o_pos    (w_pos),
        .o_status (w_status)
    );

    assign o_new_vel_x    = w_vel[0];
    assign o_new_vel_y    = w_vel[1];
    assign o_new_vel_z    = w_vel[2];
    assign o_new_pos_x    = w_pos[0];
    assign o_new_pos_y    = w_pos[1][30:0];
    assign o_new_pos_z    = w_pos[2];
    assign o_speed_status = w_status;

    // a stopped word carries zero velocity
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_speed_status == ST_STOP) |->
            (o_new_vel_x == '0) && (o_new_vel_y == '0) && (o_new_vel_z == '0))
        else $error("stopped word with nonzero velocity");

    // status code 3 is never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_speed_status == ST_KEEP) || (o_speed_status == ST_STOP)
                    || (o_speed_status == ST_CAP))
        else $error("bad speed status");

    // an empty output stage never blocks the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

endmodule

/* src/pmi_front.sv */
// front pipeline: integrate, drag, speed squared and stop/cap decision (7 stages)
`timescale 1ns / 1ps

module pmi_front
    import pmi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic              i_valid,
    input  t_vec3             i_vel,
    input  t_vec3             i_acc,
    input  t_vec3             i_pos,
    input  logic [MAG_W-1:0]  i_drag,
    input  logic [MAG_W-1:0]  i_cap,
    input  logic [DT_W-1:0]   i_dt,
    output logic              o_valid,
    output t_side             o_side,
    output logic [63:0]       o_s2
);

    logic [7:1]        r_vld;
    t_side             r1_sd, r2_sd, r3_sd, r4_sd, r5_sd, r6_sd, r7_sd;
    t_side             n2_sd, n4_sd, n7_sd;
    logic signed [48:0] r1_ad [3];
    logic [47:0]       r1_dd;
    logic [MAG_W-1:0]  r2_k;
    logic signed [63:0] r3_tk [3];
    logic [62:0]       r5_sq [3];
    logic [61:0]       r5_capsq, r6_capsq;
    logic [63:0]       r6_s2, r7_s2;
    logic [47:0]       w_dd_rnd;
    logic              w_stop, w_capf;

    // valid bits follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[6:1], i_valid};
        end
    end

    assign w_dd_rnd = (r1_dd + 48'd32768) >> 16;
    assign w_stop   = (r6_s2 <= 64'h4000_0000) || (r6_sd.cap == '0);
    assign w_capf   = r6_s2 > {2'b00, r6_capsq};

    // next side words for the stages that rewrite the velocity
    always_comb begin
        n2_sd = r1_sd;
        for (int i = 0; i < 3; i++) begin
            n2_sd.vel[i] = sat32(64'($signed(r1_sd.vel[i])) + rnd16(64'(r1_ad[i])));
        end
        n4_sd = r3_sd;
        for (int i = 0; i < 3; i++) begin
            n4_sd.vel[i] = sat32(64'($signed(r3_sd.vel[i])) - rnd16(r3_tk[i]));
        end
        // stop wins over cap
        n7_sd = r6_sd;
        if (w_stop) begin
            n7_sd.vel    = '0;
            n7_sd.status = ST_STOP;
        end else if (w_capf) begin
            n7_sd.status = ST_CAP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            // stage 1: acc * dt and drag * dt
            r1_sd.vel    <= i_vel;
            r1_sd.pos    <= i_pos;
            r1_sd.dt     <= i_dt;
            r1_sd.cap    <= i_cap;
            r1_sd.status <= ST_KEEP;
            for (int i = 0; i < 3; i++) begin
                r1_ad[i] <= 49'($signed(i_acc[i]) * $signed({1'b0, i_dt}));
            end
            r1_dd <= i_drag * i_dt;

            // stage 2: integrated velocity and drag factor
            r2_sd <= n2_sd;
            r2_k <= (w_dd_rnd > 48'h7fff_ffff) ? 31'h7fff_ffff : w_dd_rnd[MAG_W-1:0];

            // stage 3: t * k
            r3_sd <= r2_sd;
            for (int i = 0; i < 3; i++) begin
                r3_tk[i] <= $signed(r2_sd.vel[i]) * $signed({1'b0, r2_k});
            end

            // stage 4: drag applied
            r4_sd <= n4_sd;

            // stage 5: component squares and cap squared
            r5_sd <= r4_sd;
            for (int i = 0; i < 3; i++) begin
                r5_sq[i] <= 63'($signed(r4_sd.vel[i]) * $signed(r4_sd.vel[i]));
            end
            r5_capsq <= r4_sd.cap * r4_sd.cap;

            // stage 6: speed squared
            r6_sd    <= r5_sd;
            r6_capsq <= r5_capsq;
            r6_s2    <= 64'(r5_sq[0]) + 64'(r5_sq[1]) + 64'(r5_sq[2]);

            // stage 7: stop/cap decision
            r7_sd <= n7_sd;
            r7_s2 <= r6_s2;
        end
    end

    assign o_valid = r_vld[7];
    assign o_side  = r7_sd;
    assign o_s2    = r7_s2;

endmodule

/* src/pmi_sqrt.sv */
// integer square root of the speed squared, one result bit per stage
`timescale 1ns / 1ps

module pmi_sqrt
    import pmi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [63:0]       i_s2,
    output logic              o_valid,
    output t_side             o_side,
    output logic [SQRT_N-1:0] o_root
);

    logic              r_vld  [1:SQRT_N];
    t_side             r_side [1:SQRT_N];
    logic [34:0]       r_rem  [1:SQRT_N];
    logic [SQRT_N-1:0] r_q    [1:SQRT_N];
    logic [63:0]       r_x    [1:SQRT_N];

    for (genvar j = 0; j < SQRT_N; j++) begin : g_st
        logic              c_vld;
        t_side             c_side;
        logic [34:0]       c_rem, c_sh, c_trial;
        logic [SQRT_N-1:0] c_q;
        logic [63:0]       c_x;
        logic              c_ge;

        if (j == 0) begin : g_src
            assign c_vld  = i_valid;
            assign c_side = i_side;
            assign c_rem  = '0;
            assign c_q    = '0;
            assign c_x    = i_s2;
        end else begin : g_src
            assign c_vld  = r_vld[j];
            assign c_side = r_side[j];
            assign c_rem  = r_rem[j];
            assign c_q    = r_q[j];
            assign c_x    = r_x[j];
        end

        // bring down two bits, try root*4+1
        assign c_sh    = {c_rem[32:0], c_x[63:62]};
        assign c_trial = {1'b0, c_q, 2'b01};
        assign c_ge    = c_sh >= c_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_ce) begin
                r_vld[j+1] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_side[j+1] <= c_side;
                r_x[j+1]    <= {c_x[61:0], 2'b00};
                r_rem[j+1]  <= c_ge ? (c_sh - c_trial) : c_sh;
                r_q[j+1]    <= {c_q[SQRT_N-2:0], c_ge};
            end
        end
    end

    assign o_valid = r_vld[SQRT_N];
    assign o_side  = r_side[SQRT_N];
    assign o_root  = r_q[SQRT_N];

endmodule

/* src/pmi_div.sv */
// speed rescale: |v| * cap / m per lane, restoring division one bit per stage
`timescale 1ns / 1ps

module pmi_div
    import pmi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [SQRT_N-1:0] i_root,
    output logic              o_valid,
    output t_side             o_side
);

    logic             r_vld  [0:DIV_N];
    t_side            r_side [0:DIV_N];
    logic [31:0]      r_m    [0:DIV_N];
    logic [2:0]       r_neg  [0:DIV_N];
    logic [31:0]      r_rem  [0:DIV_N][3];
    logic [DIV_N-1:0] r_low  [0:DIV_N][3];
    logic [DIV_N-1:0] r_q    [0:DIV_N][3];
    logic             r_fvld;
    t_side            r_fside;
    t_side            n_fside;

    logic [31:0] w_mag [3];
    logic [62:0] w_num [3];

    // magnitudes and numerators for the first stage
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_side.vel[i][31] ? (32'd0 - i_side.vel[i]) : i_side.vel[i];
            w_num[i] = w_mag[i] * i_side.cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_side[0] <= i_side;
            r_m[0]    <= (i_root == '0) ? 32'd1 : i_root;
            for (int i = 0; i < 3; i++) begin
                r_neg[0][i] <= i_side.vel[i][31];
                r_rem[0][i] <= w_num[i][62:31];
                r_low[0][i] <= w_num[i][30:0];
                r_q[0][i]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < DIV_N; j++) begin : g_st
        logic [32:0] c_sh [3];
        logic [2:0]  c_ge;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                c_sh[i] = {r_rem[j][i], r_low[j][i][DIV_N-1]};
                c_ge[i] = c_sh[i] >= {1'b0, r_m[j]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_ce) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_side[j+1] <= r_side[j];
                r_m[j+1]    <= r_m[j];
                r_neg[j+1]  <= r_neg[j];
                for (int i = 0; i < 3; i++) begin
                    r_rem[j+1][i] <= c_ge[i] ? 32'(c_sh[i] - {1'b0, r_m[j]})
                                             : c_sh[i][31:0];
                    r_low[j+1][i] <= {r_low[j][i][DIV_N-2:0], 1'b0};
                    r_q[j+1][i]   <= {r_q[j][i][DIV_N-2:0], c_ge[i]};
                end
            end
        end
    end

    // apply sign, pick rescaled velocity only for capped words
    always_comb begin
        n_fside = r_side[DIV_N];
        if (r_side[DIV_N].status == ST_CAP) begin
            for (int i = 0; i < 3; i++) begin
                n_fside.vel[i] = r_neg[DIV_N][i] ? (32'd0 - {1'b0, r_q[DIV_N][i]})
                                                 : {1'b0, r_q[DIV_N][i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= 1'b0;
        end else if (i_ce) begin
            r_fvld <= r_vld[DIV_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_fside <= n_fside;
        end
    end

    assign o_valid = r_fvld;
    assign o_side  = r_fside;

endmodule

/* src/pmi_back.sv */
// position advance: v * dt, add, saturate, floor y (2 stages)
`timescale 1ns / 1ps

module pmi_back
    import pmi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic              i_valid,
    input  t_side             i_side,
    output logic              o_valid,
    output t_vec3             o_vel,
    output t_vec3             o_pos,
    output t_status           o_status
);

    logic               r1_vld, r2_vld;
    t_side              r1_sd;
    logic signed [48:0] r1_pd [3];
    t_vec3              r2_vel, r2_pos;
    t_status            r2_status;
    logic [WORD_W-1:0]  w_p [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (i_ce) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_p[i] = sat32(64'($signed(r1_sd.pos[i])) + rnd16(64'(r1_pd[i])));
        end
        // y never goes below ground
        if (w_p[1][31]) begin
            w_p[1] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_sd <= i_side;
            for (int i = 0; i < 3; i++) begin
                r1_pd[i] <= 49'($signed(i_side.vel[i]) * $signed({1'b0, i_side.dt}));
            end
            r2_vel    <= r1_sd.vel;
            r2_status <= r1_sd.status;
            for (int i = 0; i < 3; i++) begin
                r2_pos[i] <= w_p[i];
            end
        end
    end

    assign o_valid  = r2_vld;
    assign o_vel    = r2_vel;
    assign o_pos    = r2_pos;
    assign o_status = r2_status;

endmodule
